[rtl/core/mi3_pkg.sv]
// Shared constants and beat types for the 3x3 matrix inverse.
package mi3_pkg;

  localparam int ENTRY_BITS         = 32;
  localparam int FRACTION_BITS_DEF  = 16;
  localparam int LIMIT_BITS         = 31;
  localparam int CFG_ADDR_BITS      = 3;
  localparam int CFG_DATA_BITS      = 32;

  // register index of singular_limit
  localparam logic REG_SINGULAR_LIMIT = 1'b0;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(1);

  typedef struct packed {
    logic signed [ENTRY_BITS-1:0] in_r0c0;
    logic signed [ENTRY_BITS-1:0] in_r0c1;
    logic signed [ENTRY_BITS-1:0] in_r0c2;
    logic signed [ENTRY_BITS-1:0] in_r1c0;
    logic signed [ENTRY_BITS-1:0] in_r1c1;
    logic signed [ENTRY_BITS-1:0] in_r1c2;
    logic signed [ENTRY_BITS-1:0] in_r2c0;
    logic signed [ENTRY_BITS-1:0] in_r2c1;
    logic signed [ENTRY_BITS-1:0] in_r2c2;
  } mi3_in_t;

  typedef struct packed {
    logic signed [ENTRY_BITS-1:0] out_r0c0;
    logic signed [ENTRY_BITS-1:0] out_r0c1;
    logic signed [ENTRY_BITS-1:0] out_r0c2;
    logic signed [ENTRY_BITS-1:0] out_r1c0;
    logic signed [ENTRY_BITS-1:0] out_r1c1;
    logic signed [ENTRY_BITS-1:0] out_r1c2;
    logic signed [ENTRY_BITS-1:0] out_r2c0;
    logic signed [ENTRY_BITS-1:0] out_r2c1;
    logic signed [ENTRY_BITS-1:0] out_r2c2;
    logic                         singular;
    logic                         clipped;
  } mi3_out_t;

endpackage

[rtl/core/matrix_inverse_3x3.sv]
// 3x3 matrix inverse by adjugate over determinant, fully pipelined.
// Throughput: one matrix per cycle while out_ready does not stall the output;
//   the 32 restoring-divider stages per entry (one quotient bit each, nine
//   lanes) set the pipeline depth.
// Stalls only fill bubbles; a full stage holds when the one after it cannot move.
// Reset (rst_n low, synchronous): pipeline emptied, singular_limit back to 1.
module matrix_inverse_3x3 #(
  parameter int FRACTION_BITS = mi3_pkg::FRACTION_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  mi3_pkg::mi3_in_t                      in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output mi3_pkg::mi3_out_t                     out_data,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [mi3_pkg::CFG_ADDR_BITS-1:0]     cfg_paddr,
  input  logic [mi3_pkg::CFG_DATA_BITS-1:0]     cfg_pwdata,
  output logic [mi3_pkg::CFG_DATA_BITS-1:0]     cfg_prdata,
  output logic                                  cfg_pready
);
  import mi3_pkg::*;

  localparam int E   = ENTRY_BITS;
  localparam int F2  = 2 * FRACTION_BITS;
  localparam int PW  = 2 * E;          // 2x2 minor product
  localparam int AW  = 2 * E + 1;      // cofactor
  localparam int XW  = 2 * E + 1;      // det partial product
  localparam int TW  = 3 * E + 1;      // one det term
  localparam int DW  = 3 * E + 3;      // determinant
  localparam int NW  = AW + F2;        // scaled numerator
  localparam int HW  = NW - E;         // numerator above the quotient bits
  localparam int CW  = (HW > DW) ? HW : DW;
  localparam int LW  = LIMIT_BITS + F2;
  localparam int KW  = (LW > DW) ? LW : DW;

  // stage numbering
  localparam int S_MUL  = 0;
  localparam int S_ADJ  = 1;
  localparam int S_PP   = 2;
  localparam int S_TERM = 3;
  localparam int S_DET  = 4;
  localparam int S_ABS  = 5;
  localparam int S_PRE  = 6;
  localparam int S_DIV  = 7;           // first of E divider stages
  localparam int S_OUT  = S_DIV + E;
  localparam int NST    = S_OUT + 1;

  // cofactor j = a[P]*a[Q] - a[R]*a[S], signs of the adjugate folded in
  localparam int IP [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int IQ [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int IR [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int IS [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
  localparam int DCOL [3] = '{0, 3, 6};   // cofactors on the first row expansion

  //--------------------------------------------------------------------------
  // configuration
  //--------------------------------------------------------------------------
  logic [LIMIT_BITS-1:0] limit_r;
  logic                  cfg_sel;

  assign cfg_sel    = (cfg_paddr[CFG_ADDR_BITS-1] == REG_SINGULAR_LIMIT);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_sel ? CFG_DATA_BITS'(limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_sel) begin
      limit_r <= cfg_pwdata[LIMIT_BITS-1:0];
    end
  end

  //--------------------------------------------------------------------------
  // flow control: each stage loads when empty or when the next one moves
  //--------------------------------------------------------------------------
  logic [NST-1:0] v_r;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[S_MUL];
  assign out_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  //--------------------------------------------------------------------------
  // S_MUL: the eighteen minor products
  //--------------------------------------------------------------------------
  logic signed [E-1:0]  a [9];
  logic signed [PW-1:0] pa_r [9];
  logic signed [PW-1:0] pb_r [9];
  logic signed [E-1:0]  row0_mul_r [3];

  assign a[0] = in_data.in_r0c0;
  assign a[1] = in_data.in_r0c1;
  assign a[2] = in_data.in_r0c2;
  assign a[3] = in_data.in_r1c0;
  assign a[4] = in_data.in_r1c1;
  assign a[5] = in_data.in_r1c2;
  assign a[6] = in_data.in_r2c0;
  assign a[7] = in_data.in_r2c1;
  assign a[8] = in_data.in_r2c2;

  always_ff @(posedge clk) begin
    if (en[S_MUL]) begin
      for (int j = 0; j < 9; j++) begin
        pa_r[j] <= a[IP[j]] * a[IQ[j]];
        pb_r[j] <= a[IR[j]] * a[IS[j]];
      end
      for (int k = 0; k < 3; k++) row0_mul_r[k] <= a[k];
    end
  end

  //--------------------------------------------------------------------------
  // S_ADJ: adjugate entries, exact
  //--------------------------------------------------------------------------
  logic signed [AW-1:0] adj_r [9];
  logic signed [E-1:0]  row0_adj_r [3];

  always_ff @(posedge clk) begin
    if (en[S_ADJ]) begin
      for (int j = 0; j < 9; j++) adj_r[j] <= AW'(pa_r[j]) - AW'(pb_r[j]);
      row0_adj_r <= row0_mul_r;
    end
  end

  //--------------------------------------------------------------------------
  // S_PP: det products split into low and high halves of the cofactor
  //--------------------------------------------------------------------------
  logic signed [XW-1:0] plo_r [3];
  logic signed [XW-1:0] phi_r [3];
  logic signed [AW-1:0] adj_pp_r [9];

  always_ff @(posedge clk) begin
    if (en[S_PP]) begin
      for (int k = 0; k < 3; k++) begin
        plo_r[k] <= row0_adj_r[k] * $signed({1'b0, adj_r[DCOL[k]][E-1:0]});
        phi_r[k] <= row0_adj_r[k] * $signed(adj_r[DCOL[k]][AW-1:E]);
      end
      adj_pp_r <= adj_r;
    end
  end

  //--------------------------------------------------------------------------
  // S_TERM / S_DET: recombine halves, then sum the expansion
  //--------------------------------------------------------------------------
  logic signed [TW-1:0] term_r [3];
  logic signed [AW-1:0] adj_term_r [9];
  logic signed [DW-1:0] det_r;
  logic signed [AW-1:0] adj_det_r [9];

  always_ff @(posedge clk) begin
    if (en[S_TERM]) begin
      for (int k = 0; k < 3; k++) begin
        term_r[k] <= (TW'(phi_r[k]) <<< E) + TW'(plo_r[k]);
      end
      adj_term_r <= adj_pp_r;
    end
    if (en[S_DET]) begin
      det_r     <= DW'(term_r[0]) + DW'(term_r[1]) + DW'(term_r[2]);
      adj_det_r <= adj_term_r;
    end
  end

  //--------------------------------------------------------------------------
  // S_ABS: magnitudes and signs
  //--------------------------------------------------------------------------
  logic [DW-1:0]  mag_abs_r;
  logic [AW-1:0]  adjmag_r [9];
  logic [8:0]     neg_abs_r;
  logic [DW-1:0]  det_mag;
  logic [LW-1:0]  tol;

  assign det_mag = det_r[DW-1] ? DW'(-det_r) : DW'(det_r);
  assign tol     = {limit_r, {F2{1'b0}}};

  always_ff @(posedge clk) begin
    if (en[S_ABS]) begin
      mag_abs_r  <= det_mag;
      for (int j = 0; j < 9; j++) begin
        adjmag_r[j]  <= adj_det_r[j][AW-1] ? AW'(-adj_det_r[j]) : AW'(adj_det_r[j]);
        neg_abs_r[j] <= adj_det_r[j][AW-1] ^ det_r[DW-1];
      end
    end
  end

  //--------------------------------------------------------------------------
  // S_PRE: singular test, overflow check and divider seed. Quotient >= 2^E
  // exactly when the numerator bits above the last E reach |det|; otherwise
  // they seed the remainder and E restoring steps give the quotient.
  //--------------------------------------------------------------------------
  logic [DW-1:0] rem_d [E+1][9];
  logic [E-1:0]  low_d [E+1][9];
  logic [E-1:0]  quo_d [E+1][9];
  logic [DW-1:0] mag_d [E+1];
  logic [8:0]    neg_d [E+1];
  logic [8:0]    ovf_d [E+1];
  logic          sing_d [E+1];
  logic [NW-1:0] num [9];
  logic [CW-1:0] num_hi [9];

  always_comb begin
    for (int j = 0; j < 9; j++) begin
      num[j]    = {adjmag_r[j], {F2{1'b0}}};
      num_hi[j] = CW'(num[j][NW-1:E]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_PRE]) begin
      for (int j = 0; j < 9; j++) begin
        rem_d[0][j] <= num_hi[j][DW-1:0];
        low_d[0][j] <= num[j][E-1:0];
        quo_d[0][j] <= '0;
        ovf_d[0][j] <= (num_hi[j] >= CW'(mag_abs_r));
      end
      mag_d[0]  <= mag_abs_r;
      neg_d[0]  <= neg_abs_r;
      // exact zero is singular even with a zero limit
      sing_d[0] <= (mag_abs_r == '0) || (KW'(mag_abs_r) < KW'(tol));
    end
  end

  //--------------------------------------------------------------------------
  // divider: one quotient bit per stage, nine lanes
  //--------------------------------------------------------------------------
  for (genvar t = 0; t < E; t++) begin : g_div
    logic [DW-1:0] trial [9];
    logic [8:0]    take;

    always_comb begin
      for (int j = 0; j < 9; j++) begin
        trial[j] = {rem_d[t][j][DW-2:0], low_d[t][j][E-1-t]};
        take[j]  = (trial[j] >= mag_d[t]);
      end
    end

    always_ff @(posedge clk) begin
      if (en[S_DIV+t]) begin
        for (int j = 0; j < 9; j++) begin
          rem_d[t+1][j] <= take[j] ? (trial[j] - mag_d[t]) : trial[j];
          quo_d[t+1][j] <= {quo_d[t][j][E-2:0], take[j]};
          low_d[t+1][j] <= low_d[t][j];
        end
        mag_d[t+1]  <= mag_d[t];
        neg_d[t+1]  <= neg_d[t];
        ovf_d[t+1]  <= ovf_d[t];
        sing_d[t+1] <= sing_d[t];
      end
    end
  end

  //--------------------------------------------------------------------------
  // S_OUT: sign, saturation, singular override
  //--------------------------------------------------------------------------
  localparam logic [E-1:0] MAXNEG = {1'b1, {(E-1){1'b0}}};
  localparam logic [E-1:0] MAXPOS = {1'b0, {(E-1){1'b1}}};

  logic [E-1:0] res [9];
  logic [8:0]   clip;
  mi3_out_t     out_nxt;
  mi3_out_t     out_r;

  always_comb begin
    for (int j = 0; j < 9; j++) begin
      if (neg_d[E][j]) begin
        clip[j] = ovf_d[E][j] || (quo_d[E][j] > MAXNEG);
        res[j]  = clip[j] ? MAXNEG : E'(-quo_d[E][j]);
      end else begin
        clip[j] = ovf_d[E][j] || quo_d[E][j][E-1];
        res[j]  = clip[j] ? MAXPOS : quo_d[E][j];
      end
      if (sing_d[E]) res[j] = '0;
    end
    out_nxt.out_r0c0 = res[0];
    out_nxt.out_r0c1 = res[1];
    out_nxt.out_r0c2 = res[2];
    out_nxt.out_r1c0 = res[3];
    out_nxt.out_r1c1 = res[4];
    out_nxt.out_r1c2 = res[5];
    out_nxt.out_r2c0 = res[6];
    out_nxt.out_r2c1 = res[7];
    out_nxt.out_r2c2 = res[8];
    out_nxt.singular = sing_d[E];
    out_nxt.clipped  = !sing_d[E] && (clip != '0);
  end

  always_ff @(posedge clk) begin
    if (en[S_OUT]) out_r <= out_nxt;
  end

  assign out_data = out_r;

  //--------------------------------------------------------------------------
  // checks
  //--------------------------------------------------------------------------
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.singular |-> !out_data.clipped && out_data.out_r0c0 == '0
      && out_data.out_r1c1 == '0 && out_data.out_r2c2 == '0)
    else $error("singular beat carries nonzero data");

  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid) |-> $past(v_r[NST-2]))
    else $error("output beat appeared without a feeding stage");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r == {NST{1'b1}}) && !out_ready |-> !in_ready)
    else $error("input taken while pipeline full and stalled");

endmodule
